[hw/rtl/spfc_pkg.sv]
// ----------------------------------------------------------------------------
// Packet framer package
// Shared constants and types for the acquisition packet framer and its CRC unit.
// ----------------------------------------------------------------------------
package spfc_pkg;

   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
   localparam logic [31:0] MAGIC_WORD  = 32'h3632_4441;
   localparam logic [7:0]  HDR_VERSION = 8'h02;
   localparam logic [7:0]  HDR_FLAGS   = 8'h01;
   localparam logic [7:0]  PAD_CHANNEL = 8'hFF;
   localparam logic [31:0] PAD_SIGNED  = 32'h8000_0000;
   localparam logic [31:0] PAD_UNSIGNED = 32'hFFFF_FFFF;

   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_RECORD = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   typedef struct packed {
      logic       init;
      logic       feed;
      logic [7:0] data;
   } crc_ctrl_type;

endpackage

[hw/rtl/spfc_crc.sv]
// ----------------------------------------------------------------------------
// Packet framer CRC unit
// Reflected CRC-32 register that absorbs one byte per clock while feed is set.
// ----------------------------------------------------------------------------
module spfc_crc
   import spfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  crc_ctrl_type ctrl,
   output logic [31:0]  crc
);

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [31:0] step;

   always_comb begin
      step = crc_ff ^ {24'h0, ctrl.data};
      for (int k = 0; k < 8; k++) begin
         step = step[0] ? ((step >> 1) ^ CRC_POLY) : (step >> 1);
      end
      priority if (ctrl.init) begin
         crc_in = CRC_INIT;
      end else if (ctrl.feed) begin
         crc_in = step;
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

[hw/rtl/sweep_packet_framer_crc32_unit.sv]
// ----------------------------------------------------------------------------
// Sweep packet framer with CRC-32
// Builds a fixed-size little-endian acquisition packet as a stream of chunks.
// ----------------------------------------------------------------------------
// One request is taken at a time in an idle cycle; req_stall stays high while it
// is framed. Each chunk is loaded into the output register (waiting while the
// output is stalled), and its bytes are then fed in order into a single byte-wide
// CRC unit, which absorbs every emitted byte except those of the final CRC chunk.
// A finish pads the packet with filler records up to RECORD_SLOTS before that
// chunk. A request that is ignored or dropped leaves the framer idle.
module sweep_packet_framer_crc32_unit
   import spfc_pkg::*;
#(
   parameter int RECORD_SLOTS = 10
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [15:0]        req_failure_count,
   input  logic [7:0]         req_sweep_count,
   input  logic [31:0]        req_sweep_duration,
   input  logic [31:0]        req_packet_stamp,
   input  logic [7:0]         req_channel_id,
   input  logic               req_sample_ok,
   input  logic signed [31:0] req_raw_code,
   input  logic signed [31:0] req_sample_stamp,
   input  logic [31:0]        req_read_duration,
   input  logic [31:0]        req_conversion_duration,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_chunk_data,
   output logic [2:0]         rsp_chunk_bytes,
   output logic               rsp_packet_last
);

   localparam int SlotW = $clog2(RECORD_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EMIT = 3'b010,
      ST_FEED = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      SEG_HDR,
      SEG_REC,
      SEG_PAD,
      SEG_CRC
   } seg_type;

   state_type         state_ff, state_in;
   seg_type           seg_ff, seg_in;
   logic [2:0]        idx_ff, idx_in;
   logic [1:0]        byte_ff, byte_in;
   logic [SlotW-1:0]  slots_ff, slots_in;
   logic              open_ff, open_in;

   logic [15:0]       fail_ff;
   logic [7:0]        cnt_ff;
   logic [31:0]       total_ff, ptime_ff;
   logic [7:0]        chan_ff;
   logic              ok_ff;
   logic [31:0]       raw_ff, stamp_ff, rd_ff, cv_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic [2:0]        rsp_bytes_ff, rsp_bytes_in;
   logic              rsp_last_ff, rsp_last_in;

   crc_ctrl_type      crc_ctrl;
   logic [31:0]       crc;

   logic [31:0]       chunk_data;
   logic [2:0]        chunk_bytes;
   logic [7:0]        deficit;
   logic [15:0]       fails;
   logic              accept;
   logic              out_free;
   logic              slot_free;

   spfc_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .crc   (crc)
   );

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign slot_free = slots_ff < SlotW'(RECORD_SLOTS);
   assign deficit   = (8'(RECORD_SLOTS) > cnt_ff) ? (8'(RECORD_SLOTS) - cnt_ff) : 8'h00;
   assign fails     = fail_ff + {8'h00, deficit};

   always_comb begin
      chunk_data  = 32'h0;
      chunk_bytes = 3'd4;
      unique case (seg_ff)
         SEG_HDR: begin
            unique case (idx_ff)
               3'd0:    chunk_data = MAGIC_WORD;
               3'd1:    chunk_data = {16'(RECORD_SLOTS), HDR_FLAGS, HDR_VERSION};
               3'd2: begin
                  chunk_data  = {16'h0, fails};
                  chunk_bytes = 3'd2;
               end
               3'd3:    chunk_data = total_ff;
               default: chunk_data = ptime_ff;
            endcase
         end
         SEG_REC: begin
            unique case (idx_ff)
               3'd0: begin
                  chunk_data  = {24'h0, chan_ff};
                  chunk_bytes = 3'd1;
               end
               3'd1: begin
                  chunk_data  = {31'h0, ok_ff};
                  chunk_bytes = 3'd1;
               end
               3'd2:    chunk_data = raw_ff;
               3'd3:    chunk_data = stamp_ff;
               3'd4:    chunk_data = rd_ff;
               default: chunk_data = cv_ff;
            endcase
         end
         SEG_PAD: begin
            unique case (idx_ff)
               3'd0: begin
                  chunk_data  = {24'h0, PAD_CHANNEL};
                  chunk_bytes = 3'd1;
               end
               3'd1: begin
                  chunk_data  = 32'h0;
                  chunk_bytes = 3'd1;
               end
               3'd2:    chunk_data = PAD_SIGNED;
               3'd3:    chunk_data = PAD_SIGNED;
               3'd4:    chunk_data = PAD_UNSIGNED;
               default: chunk_data = PAD_UNSIGNED;
            endcase
         end
         default: chunk_data = ~crc;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      seg_in        = seg_ff;
      idx_in        = idx_ff;
      byte_in       = byte_ff;
      slots_in      = slots_ff;
      open_in       = open_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_last_in   = rsp_last_ff;
      crc_ctrl.init = 1'b0;
      crc_ctrl.feed = 1'b0;
      crc_ctrl.data = rsp_data_ff[8*byte_ff +: 8];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = 3'd0;
               unique case (req_cmd)
                  CMD_HEADER: begin
                     crc_ctrl.init = 1'b1;
                     slots_in      = '0;
                     open_in       = 1'b1;
                     seg_in        = SEG_HDR;
                     state_in      = ST_EMIT;
                  end
                  CMD_RECORD: begin
                     if (open_ff && slot_free) begin
                        seg_in   = SEG_REC;
                        state_in = ST_EMIT;
                     end
                  end
                  CMD_FINISH: begin
                     if (open_ff) begin
                        seg_in   = slot_free ? SEG_PAD : SEG_CRC;
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = chunk_data;
               rsp_bytes_in = chunk_bytes;
               rsp_last_in  = (seg_ff == SEG_CRC);
               byte_in      = 2'd0;
               if (seg_ff == SEG_CRC) begin
                  crc_ctrl.init = 1'b1;
                  slots_in      = '0;
                  open_in       = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_FEED;
               end
            end
         end
         ST_FEED: begin
            crc_ctrl.feed = 1'b1;
            byte_in       = byte_ff + 2'd1;
            if (byte_ff == 2'(rsp_bytes_ff - 3'd1)) begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_EMIT;
               unique case (seg_ff)
                  SEG_HDR: begin
                     if (idx_ff == 3'd4) begin
                        state_in = ST_IDLE;
                     end
                  end
                  SEG_REC: begin
                     if (idx_ff == 3'd5) begin
                        slots_in = slots_ff + SlotW'(1);
                        state_in = ST_IDLE;
                     end
                  end
                  SEG_PAD: begin
                     if (idx_ff == 3'd5) begin
                        slots_in = slots_ff + SlotW'(1);
                        idx_in   = 3'd0;
                        if (slots_ff + SlotW'(1) >= SlotW'(RECORD_SLOTS)) begin
                           seg_in = SEG_CRC;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_ff       <= SEG_HDR;
         idx_ff       <= 3'd0;
         byte_ff      <= 2'd0;
         slots_ff     <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         byte_ff      <= byte_in;
         slots_ff     <= slots_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_last_ff  <= rsp_last_in;
      if (accept) begin
         fail_ff  <= req_failure_count;
         cnt_ff   <= req_sweep_count;
         total_ff <= req_sweep_duration;
         ptime_ff <= req_packet_stamp;
         chan_ff  <= req_channel_id;
         ok_ff    <= req_sample_ok;
         raw_ff   <= req_raw_code;
         stamp_ff <= req_sample_stamp;
         rd_ff    <= req_read_duration;
         cv_ff    <= req_conversion_duration;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chunk_data  = rsp_data_ff;
   assign rsp_chunk_bytes = rsp_bytes_ff;
   assign rsp_packet_last = rsp_last_ff;

   a_state_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("framer state is not one-hot");

   a_busy_open : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> open_ff)
      else $error("framer busy without an open packet");

   a_slots_range : assert property (@(posedge clock) disable iff (reset)
      slots_ff <= SlotW'(RECORD_SLOTS))
      else $error("slot count exceeds the packet size");

   a_feed_in_chunk : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FEED) |-> (3'(byte_ff) < rsp_bytes_ff))
      else $error("CRC byte index past the chunk");

   a_last_is_crc : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_bytes_ff == 3'd4))
      else $error("last chunk is not a full CRC word");

endmodule
